// ----- src/rgb2yuv_pkg.sv -----
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// Shared types and constants of the RGB to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // frame size registers
    localparam int SIZE_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);

    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = SIZE_W'(352);
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = SIZE_W'(288);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CK_NONE = 2'd0,
        CK_U    = 2'd1,
        CK_V    = 2'd2
    } t_chroma_kind;

    // arithmetic widths
    localparam int SUM_W = 18;

endpackage

// ----- src/rgb_to_yuv420_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter
// BT.601 integer RGB to YUV 4:2:0 pixel-stream converter with frame counters.
// ----------------------------------------------------------------------------
// One RGB pixel word enters on the input channel (i_in_valid / o_in_ready),
// in frame read order. Every pixel gives one output word on the output
// channel (o_out_valid / i_out_ready) with its luma, a chroma byte and its
// kind (U on even rows at even columns, V on odd rows at even columns, none
// otherwise) and a flag on the last pixel of the frame.
// The frame size is set through the configuration channel (i_cfg_valid,
// always ready); write it only while no pixel is in flight.
// An input register holds the pixel and its position flags, then the
// constant-coefficient sums feed the output register.
// Throughput is one pixel per clock while the receiver is ready; each stage is
// a single register, and a stage takes a new word whenever it is empty or the stage after it drains.
// When the receiver stalls, the output word holds and the input register
// fills; o_in_ready drops only when both stages are full.
// Synchronous reset clears both stages, the column and row counters, and
// loads the frame size of 352 x 288.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rgb2yuv_pkg::SIZE_W-1:0]        i_cfg_data,
    // pixel input
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [7:0]                            i_in_red,
    input  logic [7:0]                            i_in_green,
    input  logic [7:0]                            i_in_blue,
    // result output
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [7:0]                            o_out_luma,
    output rgb2yuv_pkg::t_chroma_kind             o_out_chroma_kind,
    output logic [7:0]                            o_out_chroma,
    output logic                                  o_out_frame_end
);
    import rgb2yuv_pkg::*;

    logic [SIZE_W-1:0] r_frame_width;
    logic [SIZE_W-1:0] r_frame_height;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] last_col_idx;
    logic [ROW_W-1:0] last_row_idx;
    logic             last_col;
    logic             last_row;
    logic             in_fire;
    logic             cfg_fire;

    // input stage
    logic         r_s1_valid;
    logic [7:0]   r_s1_red;
    logic [7:0]   r_s1_green;
    logic [7:0]   r_s1_blue;
    t_chroma_kind r_s1_kind;
    logic         r_s1_frame_end;
    t_chroma_kind s1_kind;

    // output stage
    logic         r_out_valid;
    logic [7:0]   r_out_luma;
    t_chroma_kind r_out_kind;
    logic [7:0]   r_out_chroma;
    logic         r_out_frame_end;
    logic         s2_ready;
    logic         s1_adv;

    logic signed [SUM_W-1:0] red_s;
    logic signed [SUM_W-1:0] green_s;
    logic signed [SUM_W-1:0] blue_s;
    logic signed [SUM_W-1:0] y_sum;
    logic signed [SUM_W-1:0] u_sum;
    logic signed [SUM_W-1:0] v_sum;
    logic [7:0]              n_luma;
    logic [7:0]              n_chroma;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // last index of the effective size: zero counts as one, oversize clips
    always_comb begin
        if (r_frame_width == '0) begin
            last_col_idx = '0;
        end else if (r_frame_width >= SIZE_W'(MAX_WIDTH)) begin
            last_col_idx = COL_W'(MAX_WIDTH - 1);
        end else begin
            last_col_idx = COL_W'(r_frame_width - SIZE_W'(1));
        end
        if (r_frame_height == '0) begin
            last_row_idx = '0;
        end else if (r_frame_height >= SIZE_W'(MAX_HEIGHT)) begin
            last_row_idx = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            last_row_idx = ROW_W'(r_frame_height - SIZE_W'(1));
        end
    end

    assign last_col = (r_col >= last_col_idx);
    assign last_row = (r_row >= last_row_idx);

    always_comb begin
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
        if (r_col[0]) begin
            s1_kind = CK_NONE;
        end else if (r_row[0]) begin
            s1_kind = CK_V;
        end else begin
            s1_kind = CK_U;
        end
    end

    assign s2_ready   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && s2_ready;
    assign o_in_ready = !r_s1_valid || s2_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_red       <= i_in_red;
            r_s1_green     <= i_in_green;
            r_s1_blue      <= i_in_blue;
            r_s1_kind      <= s1_kind;
            r_s1_frame_end <= last_col && last_row;
        end
        if (s1_adv) begin
            r_out_luma      <= n_luma;
            r_out_kind      <= r_s1_kind;
            r_out_chroma    <= n_chroma;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    // constant-coefficient sums, rounding term folded in
    always_comb begin
        red_s   = SUM_W'(r_s1_red);
        green_s = SUM_W'(r_s1_green);
        blue_s  = SUM_W'(r_s1_blue);
        y_sum   = SUM_W'(66) * red_s + SUM_W'(129) * green_s
                + SUM_W'(25) * blue_s + SUM_W'(128);
        // extra 32768 keeps the chroma sum positive so bits 15:8 floor it
        u_sum   = SUM_W'(112) * blue_s - SUM_W'(38) * red_s
                - SUM_W'(74) * green_s + SUM_W'(128 + 32768);
        v_sum   = SUM_W'(112) * red_s - SUM_W'(94) * green_s
                - SUM_W'(18) * blue_s + SUM_W'(128 + 32768);
        n_luma  = y_sum[15:8] + 8'd16;
        case (r_s1_kind)
            CK_U:    n_chroma = u_sum[15:8];
            CK_V:    n_chroma = v_sum[15:8];
            default: n_chroma = 8'd0;
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_luma        = r_out_luma;
    assign o_out_chroma_kind = r_out_kind;
    assign o_out_chroma      = r_out_chroma;
    assign o_out_frame_end   = r_out_frame_end;

    // counters wrap to the frame origin right after the last pixel
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && last_col && last_row |=> r_col == '0 && r_row == '0)
        else $error("counters did not wrap after last pixel");

    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_luma >= 8'd16 && o_out_luma <= 8'd235)
        else $error("luma out of range");

    a_chroma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_chroma_kind != CK_NONE
            |-> o_out_chroma >= 8'd16 && o_out_chroma <= 8'd240)
        else $error("chroma out of range");

    a_chroma_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_chroma_kind == CK_NONE |-> o_out_chroma == 8'd0)
        else $error("chroma nonzero without a chroma sample");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the RGB to YUV 4:2:0 converter. A clocked driver
// feeds pixel words from a pending queue and a clocked monitor checks every
// output word against a local BT.601 / 4:2:0 predictor with its own frame
// counters. The frame size changes between phases while the pipe is empty,
// and the sizes include zero, the maximum and values above it. Both sides
// insert random gaps, and the receiver sometimes holds off long enough to
// back up the input.
// ----------------------------------------------------------------------------
module tb_top;
    import rgb2yuv_pkg::*;

    localparam int          CLK_HALF_NS   = 10;
    localparam int          RESET_CYCLES  = 7;
    localparam int          RANDOM_PIXELS = 1950;
    localparam int          DRAIN_CYCLES  = 6;
    localparam int          HOLD_CYCLES   = 64;
    localparam int          MAX_GAP       = 7;
    localparam longint      TIMEOUT_NS    = 10_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [SIZE_W-1:0]    SIZE_ALL_ONES = '1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0]   luma;
        t_chroma_kind kind;
        logic [7:0]   chroma;
        logic         frame_end;
    } t_yuv;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic [7:0]           in_red    = '0;
    logic [7:0]           in_green  = '0;
    logic [7:0]           in_blue   = '0;
    logic                 out_ready = 1'b0;

    logic                 o_cfg_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [7:0]           o_out_luma;
    t_chroma_kind         o_out_chroma_kind;
    logic [7:0]           o_out_chroma;
    logic                 o_out_frame_end;

    // predictor state
    logic [SIZE_W-1:0]    model_width  = RST_FRAME_WIDTH;
    logic [SIZE_W-1:0]    model_height = RST_FRAME_HEIGHT;
    int unsigned          pos_col = 0;
    int unsigned          pos_row = 0;

    t_pixel               pixel_pending[$];
    t_yuv                 yuv_expected[$];
    int                   n_errors   = 0;
    bit                   send_gaps  = 1'b0;
    bit                   recv_gaps  = 1'b0;
    int                   hold_token = 0;

    rgb_to_yuv420_converter uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_red          (in_red),
        .i_in_green        (in_green),
        .i_in_blue         (in_blue),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_out_luma        (o_out_luma),
        .o_out_chroma_kind (o_out_chroma_kind),
        .o_out_chroma      (o_out_chroma),
        .o_out_frame_end   (o_out_frame_end)
    );

    always begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v, input int unsigned lim);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > lim) begin
            return lim;
        end
        return 32'(v);
    endfunction

    // luma, decimated chroma and frame position of one accepted pixel
    task automatic predict_yuv(input t_pixel px);
        int unsigned w;
        int unsigned h;
        int          r;
        int          g;
        int          b;
        int          ysum;
        int          csum;
        logic        last_col;
        logic        last_row;
        t_yuv        res;
        w = eff_size(model_width, MAX_WIDTH);
        h = eff_size(model_height, MAX_HEIGHT);
        r = int'(px.red);
        g = int'(px.green);
        b = int'(px.blue);
        last_col = (pos_col >= w - 1);
        last_row = (pos_row >= h - 1);
        ysum = 66 * r + 129 * g + 25 * b + 128;
        res.luma = 8'((ysum >> 8) + 16);
        res.kind = CK_NONE;
        res.chroma = '0;
        if (pos_col[0] == 1'b0) begin
            if (pos_row[0] == 1'b0) begin
                res.kind = CK_U;
                csum = -38 * r - 74 * g + 112 * b;
            end else begin
                res.kind = CK_V;
                csum = 112 * r - 94 * g - 18 * b;
            end
            // offset keeps the sum positive so the shift floors
            csum = csum + 128 + 32768;
            res.chroma = csum[15:8];
        end
        res.frame_end = last_col && last_row;
        yuv_expected.push_back(res);
        if (last_col) begin
            pos_col = 0;
            pos_row = last_row ? 0 : pos_row + 1;
        end else begin
            pos_col = pos_col + 1;
        end
    endtask

    always @(posedge clk) begin : drive_pixels
        logic   busy;
        t_pixel px;
        int     wait_cnt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            wait_cnt = 0;
        end else begin
            busy = in_valid;
            if (in_valid && o_in_ready) begin
                predict_yuv(t_pixel'{in_red, in_green, in_blue});
                busy = 1'b0;
                wait_cnt = send_gaps ? $urandom_range(MAX_GAP, 0) : 0;
            end
            if (!busy) begin
                if (wait_cnt > 0) begin
                    wait_cnt = wait_cnt - 1;
                    in_valid <= 1'b0;
                end else if (pixel_pending.size() != 0) begin
                    px = pixel_pending.pop_front();
                    in_valid <= 1'b1;
                    in_red   <= px.red;
                    in_green <= px.green;
                    in_blue  <= px.blue;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : check_results
        t_yuv exp_word;
        int   wait_cnt;
        int   hold_cnt;
        int   hold_seen;
        if (!rst_n) begin
            out_ready <= 1'b0;
            wait_cnt = 0;
            hold_cnt = 0;
            hold_seen = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (yuv_expected.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual luma %0d", $time,
                             o_out_luma);
                    n_errors++;
                end else begin
                    exp_word = yuv_expected.pop_front();
                    if (o_out_luma !== exp_word.luma) begin
                        $display("%0t: luma mismatch, expected %0d, actual %0d", $time,
                                 exp_word.luma, o_out_luma);
                        n_errors++;
                    end
                    if (o_out_chroma_kind !== exp_word.kind) begin
                        $display("%0t: chroma kind mismatch, expected %0d, actual %0d", $time,
                                 exp_word.kind, o_out_chroma_kind);
                        n_errors++;
                    end
                    if (o_out_chroma !== exp_word.chroma) begin
                        $display("%0t: chroma mismatch, expected %0d, actual %0d", $time,
                                 exp_word.chroma, o_out_chroma);
                        n_errors++;
                    end
                    if (o_out_frame_end !== exp_word.frame_end) begin
                        $display("%0t: frame end mismatch, expected %0d, actual %0d", $time,
                                 exp_word.frame_end, o_out_frame_end);
                        n_errors++;
                    end
                end
                wait_cnt = recv_gaps ? $urandom_range(MAX_GAP, 0) : 0;
            end
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt = hold_cnt - 1;
                out_ready <= 1'b0;
            end else if (wait_cnt > 0) begin
                wait_cnt = wait_cnt - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_pending.push_back(t_pixel'{r, g, b});
    endtask

    // checked between edges so the driver and monitor updates have settled
    task automatic wait_idle();
        while (pixel_pending.size() != 0 || in_valid || yuv_expected.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no second assignment
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        if (idx == REG_FRAME_WIDTH) begin
            model_width = data;
        end else if (idx == REG_FRAME_HEIGHT) begin
            model_height = data;
        end
    endtask

    task automatic set_frame(input bit wr_w, input logic [SIZE_W-1:0] w, input bit wr_h,
                             input logic [SIZE_W-1:0] h, input bit spare,
                             input logic [1:0] mode);
        wait_idle();
        if (wr_w) begin
            write_reg(REG_FRAME_WIDTH, w);
        end
        if (spare) begin
            write_reg(REG_SPARE_A, SIZE_W'($urandom));
            write_reg(REG_SPARE_B, SIZE_W'($urandom));
        end
        if (wr_h) begin
            write_reg(REG_FRAME_HEIGHT, h);
        end
        cfg_valid <= 1'b0;
        send_gaps = mode[0];
        recv_gaps = mode[1];
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(15, 0))
            0:       return '0;
            1:       return SIZE_ALL_ONES;
            2:       return SIZE_W'(MAX_WIDTH);
            3:       return SIZE_W'($urandom);
            4, 5:    return SIZE_W'($urandom_range(40, 13));
            default: return SIZE_W'($urandom_range(12, 1));
        endcase
    endfunction

    initial begin : stimulus
        int unsigned  n_random;
        int unsigned  n_items;
        int unsigned  phase;
        logic [1:0]   mode;
        logic [7:0]   comp[3];
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_gaps = 1'b1;
        recv_gaps = 1'b1;

        // start of row 0 at the reset size of 352 x 288
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd255, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd0);

        // shrink mid-row: column 4 is already past the last column
        set_frame(1'b1, SIZE_W'(2), 1'b1, SIZE_W'(2), 1'b1, 2'd3);
        push_pixel(8'd0, 8'd0, 8'd255);
        push_pixel(8'd255, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd255);
        push_pixel(8'd255, 8'd0, 8'd255);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd255, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd0, 8'd255);
        push_pixel(8'd128, 8'd128, 8'd128);
        push_pixel(8'd1, 8'd254, 8'd127);

        // one-pixel frames, then zero sizes that count as one
        set_frame(1'b1, SIZE_W'(1), 1'b1, SIZE_W'(1), 1'b0, 2'd0);
        push_pixel(8'd255, 8'd0, 8'd255);
        push_pixel(8'd0, 8'd255, 8'd0);
        set_frame(1'b1, '0, 1'b1, '0, 1'b1, 2'd1);
        push_pixel(8'd0, 8'd0, 8'd255);
        push_pixel(8'd255, 8'd255, 8'd0);

        // sizes above the maximum clamp to it
        set_frame(1'b1, SIZE_ALL_ONES, 1'b1, SIZE_ALL_ONES, 1'b0, 2'd2);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd170, 8'd85, 8'd51);

        n_random = 0;
        phase = 0;
        while (n_random < RANDOM_PIXELS) begin
            mode = 2'($urandom_range(3, 0));
            n_items = $urandom_range(150, 30);
            if (phase % 5 == 2) begin
                mode = 2'd0;
                n_items = 200;
            end
            set_frame($urandom_range(3, 0) != 0, pick_size(), $urandom_range(3, 0) != 0,
                      pick_size(), $urandom_range(7, 0) == 0, mode);
            if (phase % 5 == 2) begin
                // receiver stalls while the sender keeps offering words
                hold_token <= hold_token + 1;
            end
            repeat (n_items) begin
                foreach (comp[k]) begin
                    if ($urandom_range(7, 0) == 0) begin
                        comp[k] = $urandom_range(1, 0) ? 8'hFF : 8'h00;
                    end else begin
                        comp[k] = 8'($urandom);
                    end
                end
                push_pixel(comp[0], comp[1], comp[2]);
            end
            n_random += n_items;
            phase++;
        end

        wait_idle();
        if (n_errors == 0 && yuv_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/rgb2yuv_pkg.sv
src/rgb_to_yuv420_converter.sv
tb/tb_top.sv
